@@ design/scaled_decimal_to_ascii_top_macros.svh @@
// Assertion macros for the scaled decimal to ASCII block.
`ifndef SCALED_DECIMAL_TO_ASCII_TOP_MACROS_SVH
`define SCALED_DECIMAL_TO_ASCII_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SDA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SDA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/sda_pkg.sv @@
// ----------------------------------------------------------------------------
// sda_pkg
// Widths and character codes shared by the scaled decimal to ASCII block.
// ----------------------------------------------------------------------------
package sda_pkg;
	localparam int ValueBits = 64;
	localparam int NumDigits = 20;            // digits of a 64-bit magnitude
	localparam int BcdBits   = 4 * NumDigits;
	localparam int NumStages = (ValueBits + 2) / 3;   // three bit steps a stage
	localparam int TextMax   = 21;
	localparam int MaxScale  = 18;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChPoint = 8'h2E;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [1:0] RegScale = 2'd0;
endpackage

@@ design/scaled_decimal_to_ascii_top.sv @@
// ----------------------------------------------------------------------------
// scaled_decimal_to_ascii_top
// Converts a signed scaled decimal value into ASCII text, one character per
// output transaction, most significant first.
// ----------------------------------------------------------------------------
// Channel  | direction | handshake            | payload
// in       | sink      | in_valid / in_stall  | value[63:0]
// out      | source    | out_valid / out_stall| character[7:0], last
// cfg      | APB slave | psel/penable/pready  | scale[4:0] at address 0
//
// Conversion is a pipeline: an input register takes the sign and magnitude,
// then 22 double-dabble stages (three bit steps each, one in the last) build
// 20 BCD digits, then the serializer loads the digits and counts down the
// text positions.  An item holds the out channel for its text length, 1..21
// characters, set by the digit count, the scale and the sign; the next text
// follows with no gap when it is already waiting in the last stage.  Reset
// clears all valid bits and scale.
// A stall freezes every stage that holds valid data ahead of a blocked one.
module scaled_decimal_to_ascii_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [sda_pkg::ValueBits-1:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  character,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [4:0] scale_q;
	assign pready = 1'b1;
	assign prdata = {27'd0, scale_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= '0;
		end else if (psel && penable && pwrite && paddr == sda_pkg::RegScale) begin
			scale_q <= pwdata[4:0];
		end
	end

	// double-dabble pipeline: stage k holds bcd, remaining binary, sign, scale
	logic                            v_s   [sda_pkg::NumStages+1];
	logic [sda_pkg::BcdBits-1:0]     bcd_s [sda_pkg::NumStages+1];
	logic [sda_pkg::ValueBits-1:0]   bin_s [sda_pkg::NumStages+1];
	logic                            neg_s [sda_pkg::NumStages+1];
	logic [4:0]                      sc_s  [sda_pkg::NumStages+1];
	logic                            adv   [sda_pkg::NumStages+1];
	logic                            ser_busy;
	logic                            ser_load;

	function automatic logic [sda_pkg::BcdBits-1:0] dabble(input logic [sda_pkg::BcdBits-1:0] b);
		logic [sda_pkg::BcdBits-1:0] r;
		r = b;
		for (int d = 0; d < sda_pkg::NumDigits; d++)
			if (r[4*d +: 4] >= 4'd5) r[4*d +: 4] = r[4*d +: 4] + 4'd3;
		return r;
	endfunction

	// stage advance chain: a stage moves when the next one is free or moving
	always_comb begin
		adv[sda_pkg::NumStages] = !v_s[sda_pkg::NumStages] || ser_load;
		for (int k = sda_pkg::NumStages - 1; k >= 0; k--)
			adv[k] = !v_s[k] || adv[k+1];
	end
	assign in_stall = !adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= sda_pkg::NumStages; k++) v_s[k] <= 1'b0;
		end else begin
			if (adv[0]) v_s[0] <= in_valid;
			for (int k = 1; k <= sda_pkg::NumStages; k++)
				if (adv[k]) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		logic [sda_pkg::BcdBits+sda_pkg::ValueBits-1:0] w;
		if (adv[0]) begin
			neg_s[0] <= value[sda_pkg::ValueBits-1];
			bin_s[0] <= value[sda_pkg::ValueBits-1]
				? (~value + {{(sda_pkg::ValueBits-1){1'b0}}, 1'b1}) : value;
			bcd_s[0] <= '0;
			sc_s[0]  <= (scale_q > 5'(sda_pkg::MaxScale)) ? 5'(sda_pkg::MaxScale) : scale_q;
		end
		for (int k = 1; k <= sda_pkg::NumStages; k++) begin
			if (adv[k]) begin
				w = {bcd_s[k-1], bin_s[k-1]};
				for (int j = 0; j < 3; j++)
					if ((k - 1) * 3 + j < sda_pkg::ValueBits) begin
						w = {dabble(w[sda_pkg::BcdBits+sda_pkg::ValueBits-1:sda_pkg::ValueBits]),
							w[sda_pkg::ValueBits-1:0]};
						w = w << 1;
					end
				bcd_s[k] <= w[sda_pkg::BcdBits+sda_pkg::ValueBits-1:sda_pkg::ValueBits];
				bin_s[k] <= w[sda_pkg::ValueBits-1:0];
				neg_s[k] <= neg_s[k-1];
				sc_s[k]  <= sc_s[k-1];
			end
		end
	end

	// serializer: count down positions from the leading character
	logic [sda_pkg::BcdBits-1:0] txt_q;
	logic [4:0]      pos_q, top_q, sc_q;
	logic            neg_q;
	logic [4:0]      nd;
	always_comb begin
		nd = 5'd1;
		for (int d = 0; d < sda_pkg::NumDigits; d++)
			if (bcd_s[sda_pkg::NumStages][4*d +: 4] != 4'd0) nd = 5'(d + 1);
	end
	logic [4:0] intd;
	assign intd = (nd > sc_s[sda_pkg::NumStages]) ? (nd - sc_s[sda_pkg::NumStages]) : 5'd1;

	logic [4:0] dig_i;
	always_comb begin
		logic [4:0] p;
		p = pos_q;
		character = sda_pkg::ChZero;
		dig_i = '0;
		if (neg_q && p == top_q) character = sda_pkg::ChMinus;
		else if (sc_q != 0 && p == sc_q) character = sda_pkg::ChPoint;
		else begin
			dig_i = (sc_q != 0 && p > sc_q) ? p - 5'd1 : p;
			character = sda_pkg::ChZero + {4'd0, txt_q[4*dig_i[4:0] +: 4]};
		end
	end
	assign last = (pos_q == 5'd0);
	assign out_valid = ser_busy;
	// take the next text when idle or when the final character leaves
	assign ser_load = !ser_busy || (!out_stall && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_busy <= 1'b0;
		end else if (ser_load) begin
			ser_busy <= v_s[sda_pkg::NumStages];
		end
	end
	always_ff @(posedge clk) begin
		if (ser_load) begin
			txt_q <= bcd_s[sda_pkg::NumStages];
			sc_q  <= sc_s[sda_pkg::NumStages];
			neg_q <= neg_s[sda_pkg::NumStages] && (bcd_s[sda_pkg::NumStages] != '0);
			top_q <= intd + sc_s[sda_pkg::NumStages]
				+ ((sc_s[sda_pkg::NumStages] != 0) ? 5'd1 : 5'd0) - 5'd1
				+ ((neg_s[sda_pkg::NumStages] && bcd_s[sda_pkg::NumStages] != '0) ? 5'd1 : 5'd0);
			pos_q <= intd + sc_s[sda_pkg::NumStages]
				+ ((sc_s[sda_pkg::NumStages] != 0) ? 5'd1 : 5'd0) - 5'd1
				+ ((neg_s[sda_pkg::NumStages] && bcd_s[sda_pkg::NumStages] != '0) ? 5'd1 : 5'd0);
		end else if (!out_stall) begin
			pos_q <= pos_q - 5'd1;
		end
	end

`include "scaled_decimal_to_ascii_top_macros.svh"
	`SDA_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, $stable(pos_q) && out_valid)
	`SDA_ASSERT_IMPL(a_len, clk, arst_n, out_valid, top_q <= 5'(sda_pkg::TextMax - 1))
	`SDA_ASSERT_IMPL(a_pos, clk, arst_n, out_valid, pos_q <= top_q)
	`SDA_ASSERT_NEXT(a_adv, clk, arst_n, out_valid && !out_stall && !last, pos_q == $past(pos_q) - 5'd1)
endmodule

@@ tb/tb_scaled_decimal_to_ascii_top.sv @@
// ----------------------------------------------------------------------------
// tb_scaled_decimal_to_ascii_top
// Drives signed scaled values through the decimal to ASCII block at several
// scale settings and checks every character and last marker in order.
// ----------------------------------------------------------------------------
module tb_scaled_decimal_to_ascii_top;
	timeunit 1ns;
	timeprecision 1ps;

	// One expected character of the text.
	typedef struct packed {
		logic [7:0] ch;
		logic       lst;
	} text_char_t;

	// Scoreboard: converts accepted values to text and checks the output.
	class text_scoreboard;
		text_char_t pending[$];
		int unsigned errors;
		logic [4:0] scale;

		function new();
			errors = 0;
			scale = 0;
		endfunction

		// Build the text of one accepted value and queue it.
		function void note_value(logic [63:0] v);
			logic        neg;
			logic [63:0] mag;
			logic [7:0]  rev[$];
			int          sc;
			neg = v[63];
			mag = neg ? (~v + 64'd1) : v;
			sc = (scale > sda_pkg::MaxScale) ? sda_pkg::MaxScale : scale;
			rev = {};
			if (sc != 0) begin
				for (int i = 0; i < sc; i++) begin
					rev.push_back(sda_pkg::ChZero + 8'(mag % 10));
					mag = mag / 10;
				end
				rev.push_back(sda_pkg::ChPoint);
			end
			if (mag == 0) begin
				rev.push_back(sda_pkg::ChZero);
			end else begin
				while (mag != 0) begin
					rev.push_back(sda_pkg::ChZero + 8'(mag % 10));
					mag = mag / 10;
				end
			end
			if (neg) begin
				rev.push_back(sda_pkg::ChMinus);
			end
			for (int k = rev.size() - 1; k >= 0; k--) begin
				pending.push_back('{ch: rev[k], lst: (k == 0)});
			end
		endfunction

		function void check_char(logic [7:0] ch, logic lst);
			text_char_t exp_c;
			if (pending.size() == 0) begin
				$display("%0t: unexpected character expected none actual %h last %b",
					$realtime, ch, lst);
				errors++;
				return;
			end
			exp_c = pending.pop_front();
			if (ch !== exp_c.ch) begin
				$display("%0t: character expected %h actual %h", $realtime, exp_c.ch, ch);
				errors++;
			end
			if (lst !== exp_c.lst) begin
				$display("%0t: last expected %b actual %b", $realtime, exp_c.lst, lst);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] value;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  character;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	text_scoreboard sb;
	int unsigned idle_cycles;
	bit          stall_pattern;

	scaled_decimal_to_ascii_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.character(character), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Check every accepted output transaction; count cycles with no transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check_char(character, last);
			end
			if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Receiver stall: alternates between free-flowing stretches and random stalls.
	always @(negedge clk) begin
		if ($urandom_range(0, 63) == 0) begin
			stall_pattern <= ~stall_pattern;
		end
		out_stall <= stall_pattern ? ($urandom_range(0, 2) == 0) : 1'b0;
	end

	// Watchdog: stop when nothing moves for too long.
	always @(posedge clk) begin
		if (idle_cycles > 5000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Write the scale register through a setup and an access phase.
	task automatic write_scale(input logic [4:0] s);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= sda_pkg::RegScale; pwdata <= 32'(s);
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		sb.scale = s;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// Send one value and hold it until the block takes it.
	task automatic send_value(input logic [63:0] v);
		in_valid <= 1;
		value <= v;
		do @(posedge clk); while (in_stall);
		sb.note_value(v);
		@(negedge clk);
	endtask

	task automatic drop_valid();
		in_valid <= 0;
		value <= {$urandom, $urandom};
	endtask

	// Pick a random legal value with a random number of significant bits.
	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		int          w;
		w = $urandom_range(1, 64);
		v = {$urandom, $urandom};
		if (w < 64) begin
			v = v & ((64'd1 << w) - 1);
		end
		if ($urandom_range(0, 1)) begin
			v = ~v + 1;
		end
		if (v == 64'h8000_0000_0000_0000) begin
			v = 64'h8000_0000_0000_0001;
		end
		return v;
	endfunction

	// Wait for all queued characters, then let the pipeline drain.
	task automatic drain();
		drop_valid();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [4:0] scales[$];
		logic [63:0] directed[$];
		sb = new();
		arst_n = 0;
		in_valid = 0;
		value = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed part: zero, small, extremes, leading fraction zeros.
		directed = '{64'd0, 64'd5, -64'sd5, 64'd1, -64'sd1, 64'd9,
			64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001,
			64'd1000, 64'd123456789, -64'sd987654321,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};
		scales = '{5'd0, 5'd3, 5'd18, 5'd31};
		foreach (scales[i]) begin
			write_scale(scales[i]);
			foreach (directed[j]) begin
				send_value(directed[j]);
			end
			drain();
		end

		// Random part: bursts with gaps, scale changed between phases.
		for (int ph = 0; ph < 8; ph++) begin
			write_scale(ph == 0 ? 5'd0 : ph == 1 ? 5'd18 : 5'($urandom_range(0, 31)));
			for (int n = 0; n < 36; ) begin
				int burst;
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst; b++) begin
					send_value(rand_value());
					n++;
				end
				if ($urandom_range(0, 3) != 0) begin
					drop_valid();
					repeat ($urandom_range(1, 30)) @(negedge clk);
				end
			end
			drain();
		end

		if (sb.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
